// ===== hw/rtl/arr_pkg.sv =====
package arr_pkg;

  localparam int unsigned DIM_BITS_DEF = 16;
  localparam int unsigned OUT_W        = 16;

  localparam int unsigned STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // Step addresses of the control program.
  localparam step_t S_IDLE   = 4'd0;
  localparam step_t S_ZCHK   = 4'd1;
  localparam step_t S_TWOS   = 4'd2;
  localparam step_t S_REDUCE = 4'd3;
  localparam step_t S_MKDIV  = 4'd4;
  localparam step_t S_DIVW   = 4'd5;
  localparam step_t S_SAVEW  = 4'd6;
  localparam step_t S_DIVH   = 4'd7;
  localparam step_t S_PUT    = 4'd8;
  localparam step_t S_LAST   = S_PUT;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_ZERO,
    OP_TWOS,
    OP_RED,
    OP_MKDIV,
    OP_DIV,
    OP_SAVEW,
    OP_PUT
  } op_e;

  typedef enum logic [2:0] {
    C_NONE,
    C_NO_INPUT,
    C_ANY_ZERO,
    C_EVEN_PAIR,
    C_UNEQUAL,
    C_DIV_MORE,
    C_OUT_BUSY
  } cond_e;

  // When cond holds the sequencer goes to target, otherwise to the next step (from the last step back to idle).
  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ctrl_t;

  function automatic ctrl_t ctrl_rom(input step_t step);
    ctrl_t w;
    unique case (step)
      S_IDLE:   w = '{op: OP_LOAD,  cond: C_NO_INPUT,  target: S_IDLE};
      S_ZCHK:   w = '{op: OP_ZERO,  cond: C_ANY_ZERO,  target: S_MKDIV};
      S_TWOS:   w = '{op: OP_TWOS,  cond: C_EVEN_PAIR, target: S_TWOS};
      S_REDUCE: w = '{op: OP_RED,   cond: C_UNEQUAL,   target: S_REDUCE};
      S_MKDIV:  w = '{op: OP_MKDIV, cond: C_NONE,      target: S_IDLE};
      S_DIVW:   w = '{op: OP_DIV,   cond: C_DIV_MORE,  target: S_DIVW};
      S_SAVEW:  w = '{op: OP_SAVEW, cond: C_NONE,      target: S_IDLE};
      S_DIVH:   w = '{op: OP_DIV,   cond: C_DIV_MORE,  target: S_DIVH};
      S_PUT:    w = '{op: OP_PUT,   cond: C_OUT_BUSY,  target: S_PUT};
      default:  w = '{op: OP_PUT,   cond: C_NONE,      target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/arr_in_if.sv =====
interface arr_in_if #(
  parameter int unsigned DIM_BITS = arr_pkg::DIM_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [DIM_BITS-1:0] image_width;
  logic [DIM_BITS-1:0] image_height;

  modport source (output valid, output image_width, output image_height, input ready);
  modport sink   (input valid, input image_width, input image_height, output ready);
endinterface

// ===== hw/rtl/arr_out_if.sv =====
interface arr_out_if;
  logic                       valid;
  logic                       ready;
  logic [arr_pkg::OUT_W-1:0]  ratio_numerator;
  logic [arr_pkg::OUT_W-1:0]  ratio_denominator;
  logic                       zero_error;

  modport source (output valid, output ratio_numerator, output ratio_denominator,
                  output zero_error, input ready);
  modport sink   (input valid, input ratio_numerator, input ratio_denominator,
                  input zero_error, output ready);
endinterface

// ===== hw/rtl/aspect_ratio_reducer_core.sv =====
// Channel | Direction | Payload
// --------+-----------+-----------------------------------------------------
// in_i    | sink      | image_width, image_height (DIM_BITS each)
// out_o   | source    | ratio_numerator, ratio_denominator (16), zero_error
//
// One item at a time, worked by a binary GCD loop at one step per cycle and two DIM_BITS-step divisions.
// The input is taken only in the idle step of the control program.
// The result sits in an output register, so the next item is taken while it waits.
// A stalled output holds the program in its last step until the register frees up.
// Reset clears the step counter and the output valid flag.
module aspect_ratio_reducer_core #(
  parameter int unsigned DIM_BITS = arr_pkg::DIM_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  arr_in_if.sink    in_i,
  arr_out_if.source out_o
);
  import arr_pkg::*;

  localparam int unsigned TWOS_W = (DIM_BITS > 2) ? $clog2(DIM_BITS) : 1;
  localparam int unsigned CNT_W  = TWOS_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIM_BITS - 1);

  step_t step_q, step_d;
  ctrl_t ctrl;
  logic  jump;

  logic [DIM_BITS-1:0] w_q, w_d, h_q, h_d;
  logic [DIM_BITS-1:0] a_q, a_d, b_q, b_d;
  logic [TWOS_W-1:0]   twos_q, twos_d;
  logic [DIM_BITS-1:0] rem_q, rem_d, quo_q, quo_d, num_q, num_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                err_q, err_d;

  logic                out_valid_q, out_valid_d;
  logic [OUT_W-1:0]    out_num_q, out_num_d, out_den_q, out_den_d;
  logic                out_err_q, out_err_d;

  logic [DIM_BITS:0]   rem_sh, rem_sub;
  logic                rem_ge;

  assign ctrl       = ctrl_rom(step_q);
  assign in_i.ready = (ctrl.op == OP_LOAD);

  // Restoring division step; the divisor is the GCD held in a_q.
  assign rem_sh  = {rem_q, quo_q[DIM_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, a_q};
  assign rem_ge  = (rem_sh >= {1'b0, a_q});

  always_comb begin
    unique case (ctrl.cond)
      C_NONE:      jump = 1'b0;
      C_NO_INPUT:  jump = !in_i.valid;
      C_ANY_ZERO:  jump = (a_q == '0) || (b_q == '0);
      C_EVEN_PAIR: jump = !(a_q[0] | b_q[0]);
      C_UNEQUAL:   jump = (a_q != b_q);
      C_DIV_MORE:  jump = (cnt_q != CNT_LAST);
      C_OUT_BUSY:  jump = out_valid_q && !out_o.ready;
      default:     jump = 1'b0;
    endcase
  end

  always_comb begin
    if (jump) begin
      step_d = ctrl.target;
    end else if (step_q == S_LAST) begin
      step_d = S_IDLE;
    end else begin
      step_d = step_q + step_t'(1);
    end
  end

  always_comb begin
    w_d         = w_q;
    h_d         = h_q;
    a_d         = a_q;
    b_d         = b_q;
    twos_d      = twos_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    num_d       = num_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    out_num_d   = out_num_q;
    out_den_d   = out_den_q;
    out_err_d   = out_err_q;
    out_valid_d = out_valid_q && !out_o.ready;
    unique case (ctrl.op)
      OP_LOAD: begin
        if (in_i.valid) begin
          w_d    = in_i.image_width;
          h_d    = in_i.image_height;
          a_d    = in_i.image_width;
          b_d    = in_i.image_height;
          twos_d = '0;
        end
      end
      OP_ZERO: begin
        err_d = (a_q == '0) && (b_q == '0);
        // With one side zero the divisor is the other side.
        if (a_q == '0) begin
          a_d = b_q;
        end
      end
      OP_TWOS: begin
        if (!(a_q[0] | b_q[0])) begin
          a_d    = a_q >> 1;
          b_d    = b_q >> 1;
          twos_d = twos_q + TWOS_W'(1);
        end
      end
      OP_RED: begin
        if (a_q != b_q) begin
          if (!a_q[0]) begin
            a_d = a_q >> 1;
          end else if (!b_q[0]) begin
            b_d = b_q >> 1;
          end else if (a_q > b_q) begin
            a_d = (a_q - b_q) >> 1;
          end else begin
            b_d = (b_q - a_q) >> 1;
          end
        end
      end
      OP_MKDIV: begin
        a_d   = a_q << twos_q;
        rem_d = '0;
        quo_d = w_q;
        cnt_d = '0;
      end
      OP_DIV: begin
        rem_d = rem_ge ? rem_sub[DIM_BITS-1:0] : rem_sh[DIM_BITS-1:0];
        quo_d = {quo_q[DIM_BITS-2:0], rem_ge};
        cnt_d = cnt_q + CNT_W'(1);
      end
      OP_SAVEW: begin
        num_d = quo_q;
        rem_d = '0;
        quo_d = h_q;
        cnt_d = '0;
      end
      OP_PUT: begin
        if (!jump) begin
          out_valid_d = 1'b1;
          out_num_d   = err_q ? '0 : OUT_W'(num_q);
          out_den_d   = err_q ? '0 : OUT_W'(quo_q);
          out_err_d   = err_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q       <= w_d;
    h_q       <= h_d;
    a_q       <= a_d;
    b_q       <= b_d;
    twos_q    <= twos_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    num_q     <= num_d;
    cnt_q     <= cnt_d;
    err_q     <= err_d;
    out_num_q <= out_num_d;
    out_den_q <= out_den_d;
    out_err_q <= out_err_d;
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.ratio_numerator   = out_num_q;
  assign out_o.ratio_denominator = out_den_q;
  assign out_o.zero_error        = out_err_q;

endmodule
